// ===== src/lkcsp_pkg.sv =====
// Shared types, codes and constants of the lane keep / change speed planner.
package lkcsp_pkg;

    // Lane geometry: lanes are 4 m wide, lane 0 is leftmost.
    localparam int LANE_COUNT = 3;

    // Field widths.
    localparam int D_W     = 12;   // lateral position, Q4.8
    localparam int S_W     = 21;   // longitudinal position, Q13.8
    localparam int SPEED_W = 16;   // speed, Q8.8
    localparam int LANE_W  = 2;
    localparam int REQ_W   = 2;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_SPEED_LIMIT = 1'b0;
    localparam logic REG_SPEED_STEP  = 1'b1;

    localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST = 16'd12672;  // 49.5
    localparam logic [SPEED_W-1:0] SPEED_STEP_RST  = 16'd57;     // ~0.224
    localparam logic [LANE_W-1:0]  LANE_RST        = 2'd1;       // middle lane

    // Rational constants: closing gap 0.836 = 836/1000, speed margin 2.24 = 224/100,
    // follow speed 0.95 = 19/20 with floor(y/5) done as (y * ceil(2^21/5)) >> 21.
    localparam int THRESH_W    = S_W + 10;       // holds diff * 1000
    localparam int GAP_NUM     = 836;
    localparam int GAP_DEN     = 1000;
    localparam int RAMP_W      = SPEED_W + 8;    // holds speed * 224
    localparam int MARGIN_NUM  = 224;
    localparam int MARGIN_DEN  = 100;
    localparam int FOLLOW_NUM  = 19;
    localparam int Y_W         = 19;             // (speed * 19) >> 2
    localparam int DIV5_SHIFT  = 21;
    localparam logic [Y_W-1:0] DIV5_MUL = 19'd419431;

    typedef enum logic [1:0] {
        MODE_KEEP  = 2'd0,
        MODE_LEFT  = 2'd1,
        MODE_RIGHT = 2'd2
    } lane_mode_t;

    localparam logic [REQ_W-1:0] REQ_LEFT  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RIGHT = 2'd2;

    // Item held in the input register.
    typedef struct packed {
        logic                 first_of_frame;
        logic                 last_of_frame;
        logic [D_W-1:0]       ego_d;
        logic [S_W-1:0]       ego_s;
        logic [SPEED_W-1:0]   ego_speed;
        logic [THRESH_W-1:0]  ego_thresh;     // ego_speed * 836
        logic [REQ_W-1:0]     path_request;
        logic                 car_present;
        logic [D_W-1:0]       car_d;
        logic [S_W-1:0]       car_s;
        logic [SPEED_W-1:0]   car_speed;
        logic [SPEED_W-1:0]   car_follow;     // floor(car_speed * 0.95)
    } item_t;

endpackage

// ===== src/lane_keep_change_speed_planner.sv =====
// Lane keep / change speed planner: frame-based lane mode and reference speed ramp.
// A request accepted into the input register is processed from there; the result of a
// last item is written to the output register when that item leaves the input register.
// Throughput: one request per cycle; the output register only stalls a last item.
// Reset (rst_n, async, active low): keep mode, lane 1, reference speed 0,
// speed_limit 49.5 and speed_step about 0.224; pipeline valids clear.
module lane_keep_change_speed_planner
(
    input  logic                               clk,
    input  logic                               rst_n,

    // configuration (APB-style)
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lkcsp_pkg::PADDR_W-1:0]      paddr,
    input  logic [lkcsp_pkg::PDATA_W-1:0]      pwdata,
    output logic [lkcsp_pkg::PDATA_W-1:0]      prdata,
    output logic                               pready,

    // request channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               first_of_frame,
    input  logic                               last_of_frame,
    input  logic [lkcsp_pkg::D_W-1:0]          ego_d,
    input  logic [lkcsp_pkg::S_W-1:0]          ego_s,
    input  logic [lkcsp_pkg::SPEED_W-1:0]      ego_speed,
    input  logic [lkcsp_pkg::REQ_W-1:0]        path_request,
    input  logic                               car_present,
    input  logic [lkcsp_pkg::D_W-1:0]          car_d,
    input  logic [lkcsp_pkg::S_W-1:0]          car_s,
    input  logic [lkcsp_pkg::SPEED_W-1:0]      car_speed,

    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lkcsp_pkg::SPEED_W-1:0]      reference_speed,
    output logic [lkcsp_pkg::LANE_W-1:0]       target_lane,
    output logic [lkcsp_pkg::LANE_W-1:0]       lane_mode
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [lkcsp_pkg::SPEED_W-1:0] speed_limit_reg;
    logic [lkcsp_pkg::SPEED_W-1:0] speed_step_reg;
    logic                          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg <= lkcsp_pkg::SPEED_LIMIT_RST;
            speed_step_reg  <= lkcsp_pkg::SPEED_STEP_RST;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == lkcsp_pkg::REG_SPEED_LIMIT)
            begin
                speed_limit_reg <= pwdata[lkcsp_pkg::SPEED_W-1:0];
            end
            else
            begin
                speed_step_reg <= pwdata[lkcsp_pkg::SPEED_W-1:0];
            end
        end
    end

    // Read back the addressed register, upper bits zero.
    always_comb
    begin
        if (paddr[2] == lkcsp_pkg::REG_SPEED_STEP)
        begin
            prdata = {{(lkcsp_pkg::PDATA_W-lkcsp_pkg::SPEED_W){1'b0}}, speed_step_reg};
        end
        else
        begin
            prdata = {{(lkcsp_pkg::PDATA_W-lkcsp_pkg::SPEED_W){1'b0}}, speed_limit_reg};
        end
    end

    // ------------------------------------------------------------------
    // Input register. The products that depend on the request alone are
    // formed here so the processing cycle keeps only constant scalings.
    // ------------------------------------------------------------------
    logic                              item_valid_reg;
    lkcsp_pkg::item_t                  item_reg;
    lkcsp_pkg::item_t                  item_next;
    logic                              fire;
    logic [lkcsp_pkg::Y_W+2-1:0]       car19;
    logic [lkcsp_pkg::Y_W-1:0]         car19_q4;
    logic [2*lkcsp_pkg::Y_W-1:0]       div5_prod;

    assign car19     = (lkcsp_pkg::Y_W+2)'(car_speed) * (lkcsp_pkg::Y_W+2)'(lkcsp_pkg::FOLLOW_NUM);
    assign car19_q4  = car19[lkcsp_pkg::Y_W+2-1:2];
    assign div5_prod = (2*lkcsp_pkg::Y_W)'(car19_q4) * (2*lkcsp_pkg::Y_W)'(lkcsp_pkg::DIV5_MUL);

    always_comb
    begin
        item_next.first_of_frame = first_of_frame;
        item_next.last_of_frame  = last_of_frame;
        item_next.ego_d          = ego_d;
        item_next.ego_s          = ego_s;
        item_next.ego_speed      = ego_speed;
        item_next.ego_thresh     = lkcsp_pkg::THRESH_W'(ego_speed)
                                 * lkcsp_pkg::THRESH_W'(lkcsp_pkg::GAP_NUM);
        item_next.path_request   = path_request;
        item_next.car_present    = car_present;
        item_next.car_d          = car_d;
        item_next.car_s          = car_s;
        item_next.car_speed      = car_speed;
        item_next.car_follow     = div5_prod[lkcsp_pkg::DIV5_SHIFT +: lkcsp_pkg::SPEED_W];
    end

    // Take a new request whenever the input register is empty or drains now.
    assign in_ready = !item_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    // ------------------------------------------------------------------
    // Planner state
    // ------------------------------------------------------------------
    lkcsp_pkg::lane_mode_t             mode_reg, mode_next;
    logic [lkcsp_pkg::LANE_W-1:0]      lane_reg, lane_next;
    logic [lkcsp_pkg::SPEED_W-1:0]     ref_speed_reg, ref_speed_next;
    logic                              too_close_reg, too_close_next;
    logic [lkcsp_pkg::SPEED_W-1:0]     lead_speed_reg, lead_speed_next;
    logic [lkcsp_pkg::S_W-1:0]         held_ego_s_reg;
    logic [lkcsp_pkg::SPEED_W-1:0]     held_ego_speed_reg;
    logic [lkcsp_pkg::THRESH_W-1:0]    held_thresh_reg;

    // A non-last request never waits; a last one waits for room in the output register.
    logic out_valid_reg;
    assign fire = item_valid_reg
                && (!item_reg.last_of_frame || !out_valid_reg || out_ready);

    // Lane mode update, applied on the first request of a frame.
    logic [lkcsp_pkg::D_W:0] centre_lo;   // centre - 1 m
    logic [lkcsp_pkg::D_W:0] centre_hi;   // centre + 1 m
    logic [lkcsp_pkg::LANE_W:0] lane_up;

    assign centre_lo = {1'b0, lane_reg, 2'b01, 8'h00};
    assign centre_hi = {1'b0, lane_reg, 2'b11, 8'h00};
    assign lane_up   = {1'b0, lane_reg} + (lkcsp_pkg::LANE_W+1)'(1);

    always_comb
    begin
        mode_next = mode_reg;
        lane_next = lane_reg;
        if (item_reg.first_of_frame)
        begin
            case (mode_reg)
                lkcsp_pkg::MODE_LEFT, lkcsp_pkg::MODE_RIGHT:
                begin
                    // Settle back to keep once within 1 m of the lane centre.
                    if ({1'b0, item_reg.ego_d} > centre_lo
                        && {1'b0, item_reg.ego_d} < centre_hi)
                    begin
                        mode_next = lkcsp_pkg::MODE_KEEP;
                    end
                end
                default:
                begin
                    // Drop requests that would leave the road.
                    if (item_reg.path_request == lkcsp_pkg::REQ_LEFT)
                    begin
                        if (lane_reg != '0)
                        begin
                            lane_next = lane_reg - lkcsp_pkg::LANE_W'(1);
                            mode_next = lkcsp_pkg::MODE_LEFT;
                        end
                    end
                    else if (item_reg.path_request == lkcsp_pkg::REQ_RIGHT)
                    begin
                        if (lane_up < (lkcsp_pkg::LANE_W+1)'(lkcsp_pkg::LANE_COUNT))
                        begin
                            lane_next = lane_up[lkcsp_pkg::LANE_W-1:0];
                            mode_next = lkcsp_pkg::MODE_RIGHT;
                        end
                    end
                end
            endcase
        end
    end

    // Car check against the (possibly just updated) lane and ego values.
    logic [lkcsp_pkg::S_W-1:0]      ego_s_eff;
    logic [lkcsp_pkg::SPEED_W-1:0]  ego_speed_eff;
    logic [lkcsp_pkg::THRESH_W-1:0] thresh_eff;
    logic                           too_close_base;
    logic [lkcsp_pkg::SPEED_W-1:0]  lead_speed_base;
    logic [lkcsp_pkg::D_W:0]        lane_lo;
    logic [lkcsp_pkg::D_W:0]        lane_hi;
    logic [lkcsp_pkg::S_W-1:0]      gap;
    logic [lkcsp_pkg::THRESH_W-1:0] gap_scaled;
    logic                           in_lane;
    logic                           car_hit;

    assign ego_s_eff       = item_reg.first_of_frame ? item_reg.ego_s : held_ego_s_reg;
    assign ego_speed_eff   = item_reg.first_of_frame ? item_reg.ego_speed : held_ego_speed_reg;
    assign thresh_eff      = item_reg.first_of_frame ? item_reg.ego_thresh : held_thresh_reg;
    assign too_close_base  = item_reg.first_of_frame ? 1'b0 : too_close_reg;
    assign lead_speed_base = item_reg.first_of_frame ? ref_speed_reg : lead_speed_reg;

    // Lane spans (4*lane+1) m to (4*lane+4) m, both ends open.
    assign lane_lo    = {1'b0, lane_next, 2'b01, 8'h00};
    assign lane_hi    = ({1'b0, lane_next, 2'b00, 8'h00})
                      + (lkcsp_pkg::D_W+1)'(4 * 256);
    assign in_lane    = ({1'b0, item_reg.car_d} > lane_lo) && ({1'b0, item_reg.car_d} < lane_hi);
    assign gap        = item_reg.car_s - ego_s_eff;
    assign gap_scaled = lkcsp_pkg::THRESH_W'(gap) * lkcsp_pkg::THRESH_W'(lkcsp_pkg::GAP_DEN);

    assign car_hit = item_reg.car_present
                   && in_lane
                   && (item_reg.car_s > ego_s_eff)
                   && (gap_scaled < thresh_eff)
                   && (item_reg.car_speed < ego_speed_eff);

    always_comb
    begin
        too_close_next  = too_close_base | car_hit;
        lead_speed_next = lead_speed_base;
        if (car_hit && (lead_speed_base > item_reg.car_speed))
        begin
            lead_speed_next = item_reg.car_follow;
        end
    end

    // Speed ramp at the end of the frame.
    logic [lkcsp_pkg::RAMP_W-1:0]  ref_scaled;
    logic [lkcsp_pkg::RAMP_W-1:0]  ahead_scaled;
    logic [lkcsp_pkg::SPEED_W:0]   ref_sum;

    assign ref_scaled   = lkcsp_pkg::RAMP_W'(ref_speed_reg) * lkcsp_pkg::RAMP_W'(lkcsp_pkg::MARGIN_DEN);
    assign ahead_scaled = lkcsp_pkg::RAMP_W'(lead_speed_next)
                        * lkcsp_pkg::RAMP_W'(lkcsp_pkg::MARGIN_NUM);
    assign ref_sum      = {1'b0, ref_speed_reg} + {1'b0, speed_step_reg};

    always_comb
    begin
        ref_speed_next = ref_speed_reg;
        if (item_reg.last_of_frame)
        begin
            if (!too_close_next)
            begin
                // Accelerate toward the limit, clamp at full scale.
                if (ref_speed_reg < speed_limit_reg)
                begin
                    ref_speed_next = ref_sum[lkcsp_pkg::SPEED_W] ? '1
                                   : ref_sum[lkcsp_pkg::SPEED_W-1:0];
                end
            end
            else if (ref_scaled > ahead_scaled)
            begin
                // Back off, clamp at zero.
                ref_speed_next = (ref_speed_reg > speed_step_reg)
                               ? ref_speed_reg - speed_step_reg : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= lkcsp_pkg::MODE_KEEP;
            lane_reg           <= lkcsp_pkg::LANE_RST;
            ref_speed_reg      <= '0;
            too_close_reg      <= 1'b0;
            lead_speed_reg     <= '0;
            held_ego_s_reg     <= '0;
            held_ego_speed_reg <= '0;
            held_thresh_reg    <= '0;
        end
        else if (fire)
        begin
            mode_reg       <= mode_next;
            lane_reg       <= lane_next;
            ref_speed_reg  <= ref_speed_next;
            too_close_reg  <= too_close_next;
            lead_speed_reg <= lead_speed_next;
            if (item_reg.first_of_frame)
            begin
                held_ego_s_reg     <= item_reg.ego_s;
                held_ego_speed_reg <= item_reg.ego_speed;
                held_thresh_reg    <= item_reg.ego_thresh;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: hold the frame result until taken.
    // ------------------------------------------------------------------
    logic [lkcsp_pkg::SPEED_W-1:0] res_speed_reg;
    logic [lkcsp_pkg::LANE_W-1:0]  res_lane_reg;
    lkcsp_pkg::lane_mode_t         res_mode_reg;
    logic                          emit;

    assign emit = fire && item_reg.last_of_frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_speed_reg <= ref_speed_next;
            res_lane_reg  <= lane_next;
            res_mode_reg  <= mode_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign reference_speed = res_speed_reg;
    assign target_lane     = res_lane_reg;
    assign lane_mode       = res_mode_reg;

endmodule

// ===== sim/lane_keep_change_speed_planner_tb.sv =====
// Self-checking testbench for the lane keep / change speed planner.
module lane_keep_change_speed_planner_tb;

    // Field extremes and request codes the package does not name.
    localparam int D_MAX     = (1 << lkcsp_pkg::D_W) - 1;
    localparam int S_MAX     = (1 << lkcsp_pkg::S_W) - 1;
    localparam int SPEED_MAX = (1 << lkcsp_pkg::SPEED_W) - 1;
    localparam logic [lkcsp_pkg::REQ_W-1:0] REQ_KEEP  = 2'd0;
    localparam logic [lkcsp_pkg::REQ_W-1:0] REQ_SPARE = 2'd3;   // unused code, acts as keep

    // Register map: one 32-bit word per register.
    localparam logic [lkcsp_pkg::PADDR_W-1:0] ADDR_LIMIT = {lkcsp_pkg::REG_SPEED_LIMIT, 2'b00};
    localparam logic [lkcsp_pkg::PADDR_W-1:0] ADDR_STEP  = {lkcsp_pkg::REG_SPEED_STEP, 2'b00};

    // Input register plus processing stage plus output register, with margin.
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 170;

    typedef struct {
        bit                                is_first;
        bit                                is_last;
        bit [lkcsp_pkg::D_W-1:0]           ego_d;
        bit [lkcsp_pkg::S_W-1:0]           ego_s;
        bit [lkcsp_pkg::SPEED_W-1:0]       ego_speed;
        bit [lkcsp_pkg::REQ_W-1:0]         path_request;
        bit                                car_present;
        bit [lkcsp_pkg::D_W-1:0]           car_d;
        bit [lkcsp_pkg::S_W-1:0]           car_s;
        bit [lkcsp_pkg::SPEED_W-1:0]       car_speed;
    } plan_req_t;

    typedef struct {
        bit [lkcsp_pkg::SPEED_W-1:0]       reference_speed;
        bit [lkcsp_pkg::LANE_W-1:0]        target_lane;
        lkcsp_pkg::lane_mode_t             lane_mode;
    } plan_res_t;

    // Scoreboard: tracks the planner state per accepted request and holds the
    // results that the last item of each frame must produce, oldest first.
    class speed_plan_board;
        bit [lkcsp_pkg::SPEED_W-1:0] speed_limit;
        bit [lkcsp_pkg::SPEED_W-1:0] speed_step;
        lkcsp_pkg::lane_mode_t       mode;
        bit [lkcsp_pkg::LANE_W-1:0]  lane;
        bit [lkcsp_pkg::SPEED_W-1:0] ref_speed;
        bit                          too_close;
        bit [lkcsp_pkg::SPEED_W-1:0] lead_speed;
        bit [lkcsp_pkg::S_W-1:0]     held_ego_s;
        bit [lkcsp_pkg::SPEED_W-1:0] held_ego_speed;
        plan_res_t                   planned_outputs[$];
        int                          mismatches;

        function new();
            speed_limit    = lkcsp_pkg::SPEED_LIMIT_RST;
            speed_step     = lkcsp_pkg::SPEED_STEP_RST;
            mode           = lkcsp_pkg::MODE_KEEP;
            lane           = lkcsp_pkg::LANE_RST;
            ref_speed      = '0;
            too_close      = 1'b0;
            lead_speed     = '0;
            held_ego_s     = '0;
            held_ego_speed = '0;
            mismatches     = 0;
        endfunction

        function void write_reg(logic [lkcsp_pkg::PADDR_W-1:0] addr,
                                bit [lkcsp_pkg::SPEED_W-1:0] value);
            if (addr == ADDR_LIMIT)
                speed_limit = value;
            else if (addr == ADDR_STEP)
                speed_step = value;
        endfunction

        function int pending();
            return planned_outputs.size();
        endfunction

        function void advance_mode(bit [lkcsp_pkg::D_W-1:0] ego_d,
                                   bit [lkcsp_pkg::REQ_W-1:0] req);
            int centre;
            int offset;
            if (mode == lkcsp_pkg::MODE_LEFT || mode == lkcsp_pkg::MODE_RIGHT)
            begin
                centre = (4 * lane + 2) * 256;
                offset = (ego_d > centre) ? ego_d - centre : centre - ego_d;
                if (offset < 256)
                    mode = lkcsp_pkg::MODE_KEEP;
            end
            else if (req == lkcsp_pkg::REQ_LEFT)
            begin
                if (lane > 0)
                begin
                    lane = lane - 1'b1;
                    mode = lkcsp_pkg::MODE_LEFT;
                end
            end
            else if (req == lkcsp_pkg::REQ_RIGHT)
            begin
                if (lane + 1 < lkcsp_pkg::LANE_COUNT)
                begin
                    lane = lane + 1'b1;
                    mode = lkcsp_pkg::MODE_RIGHT;
                end
            end
        endfunction

        function void judge_car(bit [lkcsp_pkg::D_W-1:0] cd, bit [lkcsp_pkg::S_W-1:0] cs,
                                bit [lkcsp_pkg::SPEED_W-1:0] cspeed);
            int unsigned lower;
            int unsigned upper;
            longint unsigned gap;
            lower = (4 * lane + 1) * 256;
            upper = (4 * lane + 4) * 256;
            if (!(cd > lower && cd < upper))
                return;
            if (cs <= held_ego_s)
                return;
            gap = cs - held_ego_s;
            if (gap * 1000 >= longint'(held_ego_speed) * 836)
                return;
            if (cspeed < held_ego_speed)
            begin
                too_close = 1'b1;
                if (lead_speed > cspeed)
                    lead_speed = lkcsp_pkg::SPEED_W'((int'(cspeed) * 95) / 100);
            end
        endfunction

        function void ramp_reference();
            int unsigned sum;
            if (!too_close)
            begin
                if (ref_speed < speed_limit)
                begin
                    sum = ref_speed + speed_step;
                    ref_speed = lkcsp_pkg::SPEED_W'((sum > SPEED_MAX) ? SPEED_MAX : sum);
                end
            end
            else if (longint'(ref_speed) * 100 > longint'(lead_speed) * 224)
            begin
                ref_speed = (ref_speed > speed_step) ? ref_speed - speed_step : '0;
            end
        endfunction

        // Note an accepted request and queue its result if it closes a frame.
        function void plan_step(plan_req_t r);
            plan_res_t res;
            if (r.is_first)
            begin
                held_ego_s     = r.ego_s;
                held_ego_speed = r.ego_speed;
                too_close      = 1'b0;
                lead_speed     = ref_speed;
                advance_mode(r.ego_d, r.path_request);
            end
            if (r.car_present)
                judge_car(r.car_d, r.car_s, r.car_speed);
            if (r.is_last)
            begin
                ramp_reference();
                res.reference_speed = ref_speed;
                res.target_lane     = lane;
                res.lane_mode       = mode;
                planned_outputs.push_back(res);
            end
        endfunction

        function void check_result(plan_res_t got);
            plan_res_t want;
            if (planned_outputs.size() == 0)
            begin
                $display("%0t: unexpected result speed=%0d lane=%0d mode=%0d", $time,
                         got.reference_speed, got.target_lane, got.lane_mode);
                mismatches++;
                return;
            end
            want = planned_outputs.pop_front();
            if (got.reference_speed !== want.reference_speed)
            begin
                $display("%0t: reference_speed expected %0d actual %0d", $time,
                         want.reference_speed, got.reference_speed);
                mismatches++;
            end
            if (got.target_lane !== want.target_lane)
            begin
                $display("%0t: target_lane expected %0d actual %0d", $time,
                         want.target_lane, got.target_lane);
                mismatches++;
            end
            if (got.lane_mode !== want.lane_mode)
            begin
                $display("%0t: lane_mode expected %0d actual %0d", $time,
                         want.lane_mode, got.lane_mode);
                mismatches++;
            end
        endfunction
    endclass

    logic                                clk;
    logic                                rst_n;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [lkcsp_pkg::PADDR_W-1:0]       paddr;
    logic [lkcsp_pkg::PDATA_W-1:0]       pwdata;
    logic [lkcsp_pkg::PDATA_W-1:0]       prdata;
    logic                                pready;
    logic                                in_valid;
    logic                                in_ready;
    logic                                first_of_frame;
    logic                                last_of_frame;
    logic [lkcsp_pkg::D_W-1:0]           ego_d;
    logic [lkcsp_pkg::S_W-1:0]           ego_s;
    logic [lkcsp_pkg::SPEED_W-1:0]       ego_speed;
    logic [lkcsp_pkg::REQ_W-1:0]         path_request;
    logic                                car_present;
    logic [lkcsp_pkg::D_W-1:0]           car_d;
    logic [lkcsp_pkg::S_W-1:0]           car_s;
    logic [lkcsp_pkg::SPEED_W-1:0]       car_speed;
    logic                                out_valid;
    logic                                out_ready;
    logic [lkcsp_pkg::SPEED_W-1:0]       reference_speed;
    logic [lkcsp_pkg::LANE_W-1:0]        target_lane;
    logic [lkcsp_pkg::LANE_W-1:0]        lane_mode;

    speed_plan_board sb;
    bit              quiet;         // no idling on either side while set
    int              sent_total;    // requests accepted so far

    lane_keep_change_speed_planner dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .first_of_frame  (first_of_frame),
        .last_of_frame   (last_of_frame),
        .ego_d           (ego_d),
        .ego_s           (ego_s),
        .ego_speed       (ego_speed),
        .path_request    (path_request),
        .car_present     (car_present),
        .car_d           (car_d),
        .car_s           (car_s),
        .car_speed       (car_speed),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .reference_speed (reference_speed),
        .target_lane     (target_lane),
        .lane_mode       (lane_mode)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the planner hangs a handshake.
    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Idle length: mostly short, now and then a long stretch.
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 3);
        else if (pick < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    function automatic plan_req_t mk(int is_first, int is_last, int e_d, int e_s, int e_speed,
                                     bit [lkcsp_pkg::REQ_W-1:0] req, int present, int c_d,
                                     int c_s, int c_speed);
        plan_req_t r;
        r.is_first     = is_first[0];
        r.is_last      = is_last[0];
        r.ego_d        = lkcsp_pkg::D_W'(e_d);
        r.ego_s        = lkcsp_pkg::S_W'(e_s);
        r.ego_speed    = lkcsp_pkg::SPEED_W'(e_speed);
        r.path_request = req;
        r.car_present  = present[0];
        r.car_d        = lkcsp_pkg::D_W'(c_d);
        r.car_s        = lkcsp_pkg::S_W'(c_s);
        r.car_speed    = lkcsp_pkg::SPEED_W'(c_speed);
        return r;
    endfunction

    // Drive one request after a random gap, hold it until accepted, then
    // hand it to the scoreboard on the accepting edge.
    task automatic send_request(input plan_req_t r);
        int gap;
        gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : idle_length();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        first_of_frame = r.is_first;
        last_of_frame  = r.is_last;
        ego_d          = r.ego_d;
        ego_s          = r.ego_s;
        ego_speed      = r.ego_speed;
        path_request   = r.path_request;
        car_present    = r.car_present;
        car_d          = r.car_d;
        car_s          = r.car_s;
        car_speed      = r.car_speed;
        in_valid       = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.plan_step(r);
        sent_total++;
    endtask

    // Drop valid and hold off until every queued result has drained and the
    // pipeline has had time to finish any request that produces no result.
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write a register (setup + access), then read it back.
    task automatic program_reg(input logic [lkcsp_pkg::PADDR_W-1:0] addr,
                               input bit [lkcsp_pkg::SPEED_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = lkcsp_pkg::PDATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_reg(addr, value);
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[lkcsp_pkg::SPEED_W-1:0] !== value)
        begin
            $display("%0t: register at %0d expected %0d actual %0d", $time, addr, value,
                     prdata[lkcsp_pkg::SPEED_W-1:0]);
            sb.mismatches++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_config(input bit [lkcsp_pkg::SPEED_W-1:0] limit,
                              input bit [lkcsp_pkg::SPEED_W-1:0] step);
        wait_drained();
        program_reg(ADDR_LIMIT, limit);
        program_reg(ADDR_STEP, step);
    endtask

    // Fill the car fields: mostly the current target lane, near the lane
    // edges, just ahead of ego and slower; sometimes anything at all.
    task automatic place_car(inout plan_req_t r, input int e_s, input int e_speed);
        int car_lane;
        car_lane = ($urandom_range(0, 9) < 7) ? int'(sb.lane) : $urandom_range(0, 3);
        if ($urandom_range(0, 4) == 0)
            r.car_d = lkcsp_pkg::D_W'($urandom);
        else
            r.car_d = lkcsp_pkg::D_W'(car_lane * 1024 + $urandom_range(200, 1080));
        r.car_s = lkcsp_pkg::S_W'(e_s + $urandom_range(0, e_speed)
                  - (($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000) : 0));
        r.car_speed = lkcsp_pkg::SPEED_W'(($urandom_range(0, 2) == 0)
                      ? $urandom : $urandom_range(0, e_speed));
    endtask

    // One well-formed frame: first item, up to six car items, last item, or one item that is both.
    task automatic random_frame();
        plan_req_t r;
        int n_cars;
        int e_s;
        int e_speed;
        int ego_lane;
        bit one_item;
        r = mk(1, 0, $urandom, $urandom, $urandom, lkcsp_pkg::REQ_W'($urandom), 0, $urandom,
               $urandom, $urandom);
        ego_lane = $urandom_range(0, lkcsp_pkg::LANE_COUNT - 1);
        if ($urandom_range(0, 3) != 0)
            r.ego_d = lkcsp_pkg::D_W'(ego_lane * 1024 + 512 + $urandom_range(0, 700) - 350);
        e_s      = int'(r.ego_s);
        e_speed  = int'(r.ego_speed);
        n_cars   = $urandom_range(0, 6);
        one_item = (n_cars == 0) && ($urandom_range(0, 1) == 1);
        r.is_last = one_item;
        if ($urandom_range(0, 2) == 0)
        begin
            r.car_present = 1'b1;
            place_car(r, e_s, e_speed);
        end
        send_request(r);
        for (int i = 0; i < n_cars; i++)
        begin
            // ego fields are ignored here: toggle them freely
            r = mk(0, 0, $urandom, $urandom, $urandom, lkcsp_pkg::REQ_W'($urandom),
                   int'($urandom_range(0, 9) != 0), 0, 0, 0);
            place_car(r, e_s, e_speed);
            send_request(r);
        end
        if (!one_item)
        begin
            r = mk(0, 1, $urandom, $urandom, $urandom, lkcsp_pkg::REQ_W'($urandom),
                   int'($urandom_range(0, 2) == 0), 0, 0, 0);
            place_car(r, e_s, e_speed);
            send_request(r);
        end
    endtask

    // Result side: random back-pressure, none while quiet.
    initial
    begin
        int stall;
        stall = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0 && !quiet)
            begin
                out_ready = 1'b0;
                stall--;
            end
            else
            begin
                out_ready = 1'b1;
                stall = 0;
                if (!quiet && $urandom_range(0, 3) == 0)
                    stall = idle_length();
            end
        end
    end

    // Sample each accepted result on the rising edge.
    always @(posedge clk)
    begin
        plan_res_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.reference_speed = reference_speed;
            got.target_lane     = target_lane;
            got.lane_mode       = lkcsp_pkg::lane_mode_t'(lane_mode);
            sb.check_result(got);
        end
    end

    initial
    begin
        sb = new();
        quiet = 1'b0;
        sent_total = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        first_of_frame = 1'b0;
        last_of_frame = 1'b0;
        ego_d = '0;
        ego_s = '0;
        ego_speed = '0;
        path_request = REQ_KEEP;
        car_present = 1'b0;
        car_d = '0;
        car_s = '0;
        car_speed = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed part, reset configuration.
        // Last item with no first item: held ego values are still zero.
        send_request(mk(0, 1, 0, 0, 0, REQ_KEEP, 1, 0, 0, 0));
        // All fields at their maximum, unused request code acts as keep.
        send_request(mk(1, 1, D_MAX, S_MAX, SPEED_MAX, REQ_SPARE, 1, D_MAX, S_MAX, SPEED_MAX));
        // Left from the middle lane, a car on the first item checked in the new lane.
        send_request(mk(1, 0, 1536, 1000, 5000, lkcsp_pkg::REQ_LEFT, 1, 640, 1100, 1000));
        // Car exactly on the upper lane bound does not count.
        send_request(mk(0, 1, 0, 0, 0, REQ_KEEP, 1, 1024, 1100, 0));
        // Near the lane centre: back to keep, the right request is not taken.
        send_request(mk(1, 1, 600, 0, 0, lkcsp_pkg::REQ_RIGHT, 0, 0, 0, 0));
        // Left request in the leftmost lane is dropped.
        send_request(mk(1, 1, 0, 0, 0, lkcsp_pkg::REQ_LEFT, 0, 0, 0, 0));
        send_request(mk(1, 1, 0, 0, 0, lkcsp_pkg::REQ_RIGHT, 0, 0, 0, 0));
        // Exactly 1 m off centre stays changing, just inside returns to keep.
        send_request(mk(1, 1, 1792, 0, 0, lkcsp_pkg::REQ_RIGHT, 0, 0, 0, 0));
        send_request(mk(1, 1, 1791, 0, 0, REQ_KEEP, 0, 0, 0, 0));
        send_request(mk(1, 1, 1536, 0, 0, lkcsp_pkg::REQ_RIGHT, 0, 0, 0, 0));
        send_request(mk(1, 1, 2560, 0, 0, REQ_KEEP, 0, 0, 0, 0));
        // Right request in the rightmost lane is dropped.
        send_request(mk(1, 1, 2560, 0, 0, lkcsp_pkg::REQ_RIGHT, 0, 0, 0, 0));
        // Car checks in lane 2: bounds, not ahead, not slower, gap limit, too close.
        send_request(mk(1, 0, 2560, 10000, 10000, REQ_KEEP, 0, 0, 0, 0));
        send_request(mk(0, 0, 0, 0, 0, REQ_KEEP, 1, 2304, 10001, 0));
        send_request(mk(0, 0, 0, 0, 0, REQ_KEEP, 1, 3071, 10000, 0));
        send_request(mk(0, 0, 0, 0, 0, REQ_KEEP, 1, 2305, 18359, 10000));
        send_request(mk(0, 0, 0, 0, 0, REQ_KEEP, 1, 3071, 18360, 0));
        send_request(mk(0, 0, 0, 0, 0, REQ_KEEP, 1, 2600, 10001, 0));
        send_request(mk(0, 1, 0, 0, 0, REQ_KEEP, 1, 3072, 10001, 0));

        // Random part: each phase starts from a drained planner with a new setting.
        for (int phase = 0; phase < 6; phase++)
        begin
            int phase_base;
            case (phase)
                0: set_config(lkcsp_pkg::SPEED_W'(SPEED_MAX), lkcsp_pkg::SPEED_W'(SPEED_MAX));
                1: set_config('0, '0);
                2: set_config(lkcsp_pkg::SPEED_LIMIT_RST, lkcsp_pkg::SPEED_STEP_RST);
                3: set_config(lkcsp_pkg::SPEED_W'($urandom),
                              lkcsp_pkg::SPEED_W'($urandom_range(0, 4000)));
                4: set_config(lkcsp_pkg::SPEED_W'(SPEED_MAX), lkcsp_pkg::SPEED_W'(1));
                default: set_config(lkcsp_pkg::SPEED_W'($urandom),
                                    lkcsp_pkg::SPEED_W'($urandom));
            endcase
            quiet = (phase == 2);
            phase_base = sent_total;
            while (sent_total - phase_base < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    random_frame();
                end
                else
                begin
                    // noise: any flags, any field values
                    send_request(mk($urandom, $urandom, $urandom, $urandom, $urandom,
                                    lkcsp_pkg::REQ_W'($urandom), $urandom, $urandom,
                                    $urandom, $urandom));
                end
            end
        end
        quiet = 1'b0;

        wait_drained();
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lkcsp_pkg.sv
src/lane_keep_change_speed_planner.sv
sim/lane_keep_change_speed_planner_tb.sv
